>>> src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SNGJ_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
		else $error("sngj assertion failed");
`define SNGJ_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("sngj forbidden condition");
`else
`define SNGJ_ASSERT(lbl, clk_s, rstn_s, prop)
`define SNGJ_NEVER(lbl, clk_s, rstn_s, cond)
`endif
`endif

>>> src/sngj_pkg.sv
package sngj_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int GAP_WIDTH_DEF = 32;
	localparam int CNT_W = 7;

	localparam logic [1:0] SEQ_MODE_8 = 2'd0;
	localparam logic [1:0] SEQ_MODE_16 = 2'd1;
	localparam logic [1:0] SEQ_MODE_32 = 2'd2;
	localparam logic [1:0] SEQ_MODE_RSVD = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIVG,
		S_GTAKE,
		S_MULQ,
		S_SQADD,
		S_CHK,
		S_DIVM,
		S_MTAKE,
		S_MULS,
		S_SLOAD,
		S_DIVS,
		S_DLOAD,
		S_DIVV,
		S_VTAKE,
		S_SQRT,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		DSRC_MEAN,
		DSRC_SQ,
		DSRC_DIFF
	} div_src_t;

	typedef struct packed {
		logic capture;
		logic div_load;
		div_src_t div_src;
		logic div_step;
		logic gtake;
		logic mul_step;
		logic [2:0] mul_idx;
		logic sq_add;
		logic mtake;
		logic sqrt_load;
		logic sqrt_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic last;
		logic count_nz;
		logic out_free;
	} stat_t;

endpackage

>>> src/sngj_in_if.sv
interface sngj_in_if;
	logic valid;
	logic ready;
	logic [63:0] arrival_ns;
	logic [31:0] seq_num;
	logic last_packet;

	modport source (output valid, output arrival_ns, output seq_num, output last_packet,
		input ready);
	modport sink (input valid, input arrival_ns, input seq_num, input last_packet,
		output ready);
endinterface

>>> src/sngj_out_if.sv
interface sngj_out_if;
	logic valid;
	logic ready;
	logic [31:0] norm_gap_ns;
	logic gap_valid;
	logic [31:0] mean_gap_ns;
	logic [31:0] gap_sd_ns;
	logic stats_valid;
	logic saturated;

	modport source (output valid, output norm_gap_ns, output gap_valid, output mean_gap_ns,
		output gap_sd_ns, output stats_valid, output saturated, input ready);
	modport sink (input valid, input norm_gap_ns, input gap_valid, input mean_gap_ns,
		input gap_sd_ns, input stats_valid, input saturated, output ready);
endinterface

>>> src/sngj_ctrl.sv
`include "assert_macros.svh"

module sngj_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sngj_pkg::stat_t status,
	output sngj_pkg::cmd_t cmd
);

	sngj_pkg::state_t st_q, nxt_st;
	logic [sngj_pkg::CNT_W-1:0] cnt_q, nxt_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sngj_pkg::S_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= nxt_st;
			cnt_q <= nxt_cnt;
		end
	end

	always_comb begin
		nxt_st = st_q;
		nxt_cnt = cnt_q;
		cmd = '0;
		cmd.div_src = sngj_pkg::DSRC_MEAN;
		cmd.mul_idx = cnt_q[2:0];
		in_ready = 1'b0;
		case (st_q)
			sngj_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					nxt_cnt = '1;
					nxt_st = status.have_prev ? sngj_pkg::S_DIVG : sngj_pkg::S_CHK;
				end
			end
			sngj_pkg::S_DIVG: begin
				cmd.div_step = 1'b1;
				nxt_cnt = cnt_q - 1'b1;
				if (cnt_q == sngj_pkg::CNT_W'(64)) begin
					nxt_st = sngj_pkg::S_GTAKE;
				end
			end
			sngj_pkg::S_GTAKE: begin
				cmd.gtake = 1'b1;
				nxt_cnt = '0;
				nxt_st = sngj_pkg::S_MULQ;
			end
			sngj_pkg::S_MULQ: begin
				cmd.mul_step = 1'b1;
				nxt_cnt = cnt_q + 1'b1;
				if (cnt_q == sngj_pkg::CNT_W'(4)) begin
					nxt_st = sngj_pkg::S_SQADD;
				end
			end
			sngj_pkg::S_SQADD: begin
				cmd.sq_add = 1'b1;
				nxt_st = sngj_pkg::S_CHK;
			end
			sngj_pkg::S_CHK: begin
				if (status.last && status.count_nz) begin
					cmd.div_load = 1'b1;
					cmd.div_src = sngj_pkg::DSRC_MEAN;
					nxt_cnt = '1;
					nxt_st = sngj_pkg::S_DIVM;
				end else begin
					nxt_st = sngj_pkg::S_DONE;
				end
			end
			sngj_pkg::S_DIVM: begin
				cmd.div_step = 1'b1;
				nxt_cnt = cnt_q - 1'b1;
				if (cnt_q == sngj_pkg::CNT_W'(64)) begin
					nxt_st = sngj_pkg::S_MTAKE;
				end
			end
			sngj_pkg::S_MTAKE: begin
				cmd.mtake = 1'b1;
				nxt_cnt = '0;
				nxt_st = sngj_pkg::S_MULS;
			end
			sngj_pkg::S_MULS: begin
				cmd.mul_step = 1'b1;
				nxt_cnt = cnt_q + 1'b1;
				if (cnt_q == sngj_pkg::CNT_W'(4)) begin
					nxt_st = sngj_pkg::S_SLOAD;
				end
			end
			sngj_pkg::S_SLOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_src = sngj_pkg::DSRC_SQ;
				nxt_cnt = '1;
				nxt_st = sngj_pkg::S_DIVS;
			end
			sngj_pkg::S_DIVS: begin
				cmd.div_step = 1'b1;
				nxt_cnt = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					nxt_st = sngj_pkg::S_DLOAD;
				end
			end
			sngj_pkg::S_DLOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_src = sngj_pkg::DSRC_DIFF;
				nxt_cnt = '1;
				nxt_st = sngj_pkg::S_DIVV;
			end
			sngj_pkg::S_DIVV: begin
				cmd.div_step = 1'b1;
				nxt_cnt = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					nxt_st = sngj_pkg::S_VTAKE;
				end
			end
			sngj_pkg::S_VTAKE: begin
				cmd.sqrt_load = 1'b1;
				nxt_cnt = sngj_pkg::CNT_W'(31);
				nxt_st = sngj_pkg::S_SQRT;
			end
			sngj_pkg::S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				nxt_cnt = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					nxt_st = sngj_pkg::S_DONE;
				end
			end
			sngj_pkg::S_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					nxt_st = sngj_pkg::S_IDLE;
				end
			end
			default: begin
				nxt_st = sngj_pkg::S_IDLE;
			end
		endcase
	end

	// The counter runs from 127 down to 64 for a 64-bit quotient, and to 0 for 128 bits.
	`SNGJ_ASSERT(a_busy_after_accept, clk, arst_n, cmd.capture |=> !in_ready)
	`SNGJ_ASSERT(a_load_when_free, clk, arst_n, cmd.out_load |-> status.out_free)
	`SNGJ_ASSERT(a_gap_div_ends, clk, arst_n,
		(st_q == sngj_pkg::S_DIVG && cnt_q == sngj_pkg::CNT_W'(64)) |=>
		(st_q == sngj_pkg::S_GTAKE))

endmodule

>>> src/sngj_dp.sv
`include "assert_macros.svh"

module sngj_dp #(
	parameter int COUNT_WIDTH = sngj_pkg::COUNT_WIDTH_DEF,
	parameter int GAP_WIDTH = sngj_pkg::GAP_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_data,
	input logic [63:0] arrival_ns,
	input logic [31:0] seq_num,
	input logic last_packet,
	input sngj_pkg::cmd_t cmd,
	output sngj_pkg::stat_t status,
	sngj_out_if.source out_ch
);

	logic [1:0] mode_q;
	logic [63:0] prev_time_q;
	logic [31:0] prev_seq_q;
	logic have_prev_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [63:0] sum_q;
	logic [127:0] sq_q;
	logic sat_q;
	logic gv_q;
	logic last_q;
	logic acc_en_q;
	logic [GAP_WIDTH-1:0] q_q;
	logic [31:0] mean_q;

	logic [127:0] div_n_q;
	logic [63:0] div_r_q;
	logic [63:0] div_d_q;
	logic [127:0] div_qt_q;

	logic [63:0] mul_a_q;
	logic [63:0] pp_s1;
	logic [1:0] psh_s1;
	logic [127:0] mul_acc_q;

	logic [63:0] sq_n_q;
	logic [63:0] sq_res_q;
	logic [63:0] sq_bit_q;

	logic out_valid_q;
	logic [31:0] out_norm_q;
	logic out_gv_q;
	logic [31:0] out_mean_q;
	logic [31:0] out_sd_q;
	logic out_sv_q;
	logic out_sat_q;

	logic [31:0] seq_mask;
	logic [31:0] seq_m;
	logic [31:0] sdiff;
	logic time_back;
	logic [63:0] gap;
	logic [64:0] rsh;
	logic r_ge;
	logic q_over;
	logic [GAP_WIDTH-1:0] q_sat;
	logic count_full;
	logic [64:0] sum_add;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [127:0] pp_shift;
	logic [63:0] sq_t;
	logic [127:0] diff;

	always_comb begin
		case (mode_q)
			sngj_pkg::SEQ_MODE_8: seq_mask = 32'h0000_00ff;
			sngj_pkg::SEQ_MODE_16: seq_mask = 32'h0000_ffff;
			default: seq_mask = 32'hffff_ffff;
		endcase
		seq_m = seq_num & seq_mask;
		sdiff = (seq_m - prev_seq_q) & seq_mask;
		if (sdiff == '0) begin
			sdiff = 32'd1;
		end
		time_back = arrival_ns < prev_time_q;
		gap = time_back ? 64'd0 : (arrival_ns - prev_time_q);

		rsh = {div_r_q, div_n_q[127]};
		r_ge = rsh >= {1'b0, div_d_q};

		q_over = div_qt_q[63:0] > 64'({GAP_WIDTH{1'b1}});
		q_sat = q_over ? {GAP_WIDTH{1'b1}} : div_qt_q[GAP_WIDTH-1:0];
		count_full = count_q == {COUNT_WIDTH{1'b1}};
		sum_add = {1'b0, sum_q} + 65'(q_sat);

		mul_x = cmd.mul_idx[1] ? mul_a_q[63:32] : mul_a_q[31:0];
		mul_y = (cmd.mul_idx[1] ^ cmd.mul_idx[0]) ? mul_a_q[63:32] : mul_a_q[31:0];
		case (psh_s1)
			2'd0: pp_shift = {64'd0, pp_s1};
			2'd2: pp_shift = {pp_s1, 64'd0};
			default: pp_shift = {32'd0, pp_s1, 32'd0};
		endcase

		sq_t = sq_res_q + sq_bit_q;
		diff = sq_q - div_qt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sngj_pkg::SEQ_MODE_8;
			prev_time_q <= '0;
			prev_seq_q <= '0;
			have_prev_q <= 1'b0;
			count_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if (cmd.capture) begin
				prev_time_q <= arrival_ns;
				prev_seq_q <= seq_m;
				have_prev_q <= 1'b1;
				if (have_prev_q && time_back) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.gtake) begin
				if (q_over || count_full || sum_add[64]) begin
					sat_q <= 1'b1;
				end
				if (!count_full) begin
					count_q <= count_q + 1'b1;
					sum_q <= sum_add[64] ? '1 : sum_add[63:0];
				end
			end
			if (cmd.sq_add && acc_en_q) begin
				sq_q <= sq_q + mul_acc_q;
			end
			if (cmd.mtake && div_qt_q[63:32] != '0) begin
				sat_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					prev_time_q <= '0;
					prev_seq_q <= '0;
					have_prev_q <= 1'b0;
					count_q <= '0;
					sum_q <= '0;
					sq_q <= '0;
					sat_q <= 1'b0;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gv_q <= have_prev_q;
			last_q <= last_packet;
			div_n_q <= {gap, 64'd0};
			div_d_q <= {32'd0, sdiff};
			div_r_q <= '0;
			div_qt_q <= '0;
		end
		if (cmd.div_load) begin
			case (cmd.div_src)
				sngj_pkg::DSRC_MEAN: div_n_q <= {sum_q, 64'd0};
				sngj_pkg::DSRC_SQ: div_n_q <= mul_acc_q;
				default: div_n_q <= diff;
			endcase
			div_d_q <= 64'(count_q);
			div_r_q <= '0;
			div_qt_q <= '0;
		end
		if (cmd.div_step) begin
			div_n_q <= {div_n_q[126:0], 1'b0};
			div_r_q <= r_ge ? 64'(rsh - {1'b0, div_d_q}) : rsh[63:0];
			div_qt_q <= {div_qt_q[126:0], r_ge};
		end
		if (cmd.gtake) begin
			q_q <= q_sat;
			acc_en_q <= !count_full;
			mul_a_q <= 64'(q_sat);
			mul_acc_q <= '0;
		end
		if (cmd.mtake) begin
			mean_q <= (div_qt_q[63:32] != '0) ? 32'hffff_ffff : div_qt_q[31:0];
			mul_a_q <= sum_q;
			mul_acc_q <= '0;
		end
		if (cmd.mul_step) begin
			pp_s1 <= mul_x * mul_y;
			psh_s1 <= cmd.mul_idx[1:0];
			if (cmd.mul_idx != 3'd0) begin
				mul_acc_q <= mul_acc_q + pp_shift;
			end
		end
		if (cmd.sqrt_load) begin
			sq_n_q <= (div_qt_q[127:64] != '0) ? '1 : div_qt_q[63:0];
			sq_res_q <= '0;
			sq_bit_q <= 64'd1 << 62;
		end
		if (cmd.sqrt_step) begin
			if (sq_n_q >= sq_t) begin
				sq_n_q <= sq_n_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.out_load) begin
			out_norm_q <= gv_q ? 32'(q_q) : 32'd0;
			out_gv_q <= gv_q;
			out_sv_q <= last_q && (count_q != '0);
			out_mean_q <= (last_q && count_q != '0) ? mean_q : 32'd0;
			out_sd_q <= (last_q && count_q != '0) ? sq_res_q[31:0] : 32'd0;
			out_sat_q <= sat_q;
		end
	end

	assign status.have_prev = have_prev_q;
	assign status.last = last_q;
	assign status.count_nz = count_q != '0;
	assign status.out_free = !out_valid_q || out_ch.ready;

	assign out_ch.valid = out_valid_q;
	assign out_ch.norm_gap_ns = out_norm_q;
	assign out_ch.gap_valid = out_gv_q;
	assign out_ch.mean_gap_ns = out_mean_q;
	assign out_ch.gap_sd_ns = out_sd_q;
	assign out_ch.stats_valid = out_sv_q;
	assign out_ch.saturated = out_sat_q;

	`SNGJ_ASSERT(a_norm_zero, clk, arst_n,
		(out_ch.valid && !out_ch.gap_valid) |-> (out_ch.norm_gap_ns == '0))
	`SNGJ_ASSERT(a_stats_need_gap, clk, arst_n,
		(out_ch.valid && out_ch.stats_valid) |-> out_ch.gap_valid)
	`SNGJ_ASSERT(a_stats_zero, clk, arst_n,
		(out_ch.valid && !out_ch.stats_valid) |->
		(out_ch.mean_gap_ns == '0 && out_ch.gap_sd_ns == '0))

endmodule

>>> src/seq_normalized_gap_jitter_core.sv
// Normalized packet gap and jitter statistics.
// The input channel carries one word per received packet: arrival time in ns,
// sequence number and a last-packet flag. The output channel carries one word per
// input word: the gap divided by the sequence step and a sticky saturation flag,
// and on the last packet of a set also the mean and standard deviation of those
// gaps. The set state clears after the last packet's word is loaded for output.
// cfg_we with cfg_data selects 8-, 16- or 32-bit sequence numbers; the user must
// write it only while idle, which the block does not enforce. One word is worked
// on at a time. A restoring divider retires one quotient bit per cycle (64 bits
// for the gap) and a 32x32 multiplier forms the square. A last packet adds a 64-bit
// mean division, the square of the sum, two 128-bit divisions and a 32-step
// square root. The output register holds a finished word while the next input is
// accepted and worked on; a stalled receiver blocks the block only when the next
// word is finished too. Reset clears set state and output valid; sets 8-bit mode.
module seq_normalized_gap_jitter_core #(
	parameter int COUNT_WIDTH = sngj_pkg::COUNT_WIDTH_DEF,
	parameter int GAP_WIDTH = sngj_pkg::GAP_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_data,
	sngj_in_if.sink in_ch,
	sngj_out_if.source out_ch
);

	sngj_pkg::cmd_t cmd;
	sngj_pkg::stat_t status;
	logic ready;

	assign in_ch.ready = ready;

	sngj_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(ready),
		.status(status),
		.cmd(cmd)
	);

	sngj_dp #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.GAP_WIDTH(GAP_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.arrival_ns(in_ch.arrival_ns),
		.seq_num(in_ch.seq_num),
		.last_packet(in_ch.last_packet),
		.cmd(cmd),
		.status(status),
		.out_ch(out_ch)
	);

endmodule
